@@ rtl/core/slpg_pkg.sv @@
`timescale 1ns / 1ps

package slpg_pkg;

   localparam int PERIOD_WIDTH = 16;
   localparam int LIMIT_WIDTH  = 5;
   localparam int CSR_AW       = 5;
   localparam int CSR_DW       = 32;

   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_LINK  = 2'd1;
   localparam logic [1:0] CMD_BURST = 2'd2;

   localparam logic [2:0] REG_FAST_PERIOD = 3'd0;
   localparam logic [2:0] REG_SLOW_PERIOD = 3'd1;
   localparam logic [2:0] REG_SLOW_ON     = 3'd2;
   localparam logic [2:0] REG_BURST_STEP  = 3'd3;
   localparam logic [2:0] REG_BURST_LIMIT = 3'd4;

   localparam logic [PERIOD_WIDTH-1:0] FAST_PERIOD_RST = 16'd125;
   localparam logic [PERIOD_WIDTH-1:0] SLOW_PERIOD_RST = 16'd2000;
   localparam logic [PERIOD_WIDTH-1:0] SLOW_ON_RST     = 16'd125;
   localparam logic [PERIOD_WIDTH-1:0] BURST_STEP_RST  = 16'd100;
   localparam logic [LIMIT_WIDTH-1:0]  BURST_LIMIT_RST = 5'd6;

   typedef struct packed {
      logic [1:0] command;
      logic       connected_level;
   } slpg_req_type;

   typedef struct packed {
      logic led_on;
      logic burst_running;
      logic link_up;
   } slpg_rsp_type;

   typedef struct packed {
      logic [PERIOD_WIDTH-1:0] fast_period_ticks;
      logic [PERIOD_WIDTH-1:0] slow_period_ticks;
      logic [PERIOD_WIDTH-1:0] slow_on_ticks;
      logic [PERIOD_WIDTH-1:0] burst_step_ticks;
      logic [LIMIT_WIDTH-1:0]  burst_step_limit;
   } slpg_cfg_type;

endpackage

@@ rtl/core/status_led_pattern_generator.sv @@
`timescale 1ns / 1ps

// Status LED pattern generator.
// Input channel (req_valid / req_stall / req_item) carries one command per
// transfer: a time tick, a connection level change or a burst trigger.
// Result channel (rsp_valid / rsp_stall / rsp_item) returns one item per
// command: LED level, burst-in-progress flag and link flag after that command.
// Periods and the burst step limit are set through the APB-style register
// port at byte addresses 0, 4, 8, 12 and 16; write them only while idle.
// A command accepted into the input register is processed into the result
// register once that register is free, which raises rsp_valid; the result
// transfers when rsp_stall is low.
// Throughput: one command per cycle while the receiver does not stall, set
// by the combinational state update between the input and result registers.
// Reset clears all timers, the LED and the link and burst state, and loads
// the register defaults; both channels come up empty.
// When the receiver stalls, the result register holds; the input register
// takes one more if empty, then req_stall rises until the result moves.
module status_led_pattern_generator
   import slpg_pkg::*;
#(
   parameter int COUNT_WIDTH = 16
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  slpg_req_type      req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output slpg_rsp_type      rsp_item,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   slpg_cfg_type cfg;
   slpg_req_type in_item_ff;
   logic         in_valid_ff, in_valid_in;
   slpg_rsp_type rsp_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   slpg_rsp_type result;
   logic         out_free;
   logic         process;
   logic         accept;

   slpg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   slpg_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .item_en (process),
      .item    (in_item_ff),
      .result  (result)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign process   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !process);
   assign rsp_valid_in = process || (rsp_valid_ff && rsp_stall);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold payloads unless a new transfer lands
   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_item;
      end
      if (process) begin
         rsp_item_ff <= result;
      end
   end

endmodule

@@ rtl/core/slpg_csr.sv @@
`timescale 1ns / 1ps

module slpg_csr
   import slpg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [CSR_AW-1:0]   paddr,
   input  logic [CSR_DW-1:0]   pwdata,
   output logic [CSR_DW-1:0]   prdata,
   output logic                pready,
   output slpg_cfg_type        cfg
);

   slpg_cfg_type cfg_ff;
   slpg_cfg_type cfg_in;
   logic [2:0]   reg_sel;
   logic         wr_en;

   assign reg_sel = paddr[CSR_AW-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_FAST_PERIOD: cfg_in.fast_period_ticks = pwdata[PERIOD_WIDTH-1:0];
            REG_SLOW_PERIOD: cfg_in.slow_period_ticks = pwdata[PERIOD_WIDTH-1:0];
            REG_SLOW_ON:     cfg_in.slow_on_ticks     = pwdata[PERIOD_WIDTH-1:0];
            REG_BURST_STEP:  cfg_in.burst_step_ticks  = pwdata[PERIOD_WIDTH-1:0];
            REG_BURST_LIMIT: cfg_in.burst_step_limit  = pwdata[LIMIT_WIDTH-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_FAST_PERIOD: prdata = CSR_DW'(cfg_ff.fast_period_ticks);
         REG_SLOW_PERIOD: prdata = CSR_DW'(cfg_ff.slow_period_ticks);
         REG_SLOW_ON:     prdata = CSR_DW'(cfg_ff.slow_on_ticks);
         REG_BURST_STEP:  prdata = CSR_DW'(cfg_ff.burst_step_ticks);
         REG_BURST_LIMIT: prdata = CSR_DW'(cfg_ff.burst_step_limit);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fast_period_ticks <= FAST_PERIOD_RST;
         cfg_ff.slow_period_ticks <= SLOW_PERIOD_RST;
         cfg_ff.slow_on_ticks     <= SLOW_ON_RST;
         cfg_ff.burst_step_ticks  <= BURST_STEP_RST;
         cfg_ff.burst_step_limit  <= BURST_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/core/slpg_core.sv @@
`timescale 1ns / 1ps

module slpg_core
   import slpg_pkg::*;
#(
   parameter int COUNT_WIDTH = 16
)
(
   input  logic         clock,
   input  logic         reset,
   input  slpg_cfg_type cfg,
   input  logic         item_en,
   input  slpg_req_type item,
   output slpg_rsp_type result
);

   localparam int CMP_W = (COUNT_WIDTH > PERIOD_WIDTH) ? COUNT_WIDTH : PERIOD_WIDTH;

   logic                   link_ff, link_in;
   logic                   toggle_ff, toggle_in;
   logic                   led_ff, led_in;
   logic                   burst_ff, burst_in;
   logic [LIMIT_WIDTH-1:0] count_ff, count_in;
   logic [COUNT_WIDTH-1:0] fast_cnt_ff, fast_cnt_in;
   logic [COUNT_WIDTH-1:0] slow_cnt_ff, slow_cnt_in;
   logic [COUNT_WIDTH-1:0] off_cnt_ff, off_cnt_in;
   logic                   off_armed_ff, off_armed_in;
   logic [COUNT_WIDTH-1:0] step_cnt_ff, step_cnt_in;
   logic                   step_armed_ff, step_armed_in;
   logic                   off_new;

   // Counter fires when the incremented value reaches the period or saturates.
   function automatic logic fires(input logic [COUNT_WIDTH-1:0] cnt,
                                  input logic [PERIOD_WIDTH-1:0] period);
      logic [COUNT_WIDTH-1:0] nxt;
      begin
         nxt = cnt + COUNT_WIDTH'(1);
         return (CMP_W'(nxt) >= CMP_W'(period)) || (&nxt);
      end
   endfunction

   always_comb begin
      link_in       = link_ff;
      toggle_in     = toggle_ff;
      led_in        = led_ff;
      burst_in      = burst_ff;
      count_in      = count_ff;
      fast_cnt_in   = fast_cnt_ff;
      slow_cnt_in   = slow_cnt_ff;
      off_cnt_in    = off_cnt_ff;
      off_armed_in  = off_armed_ff;
      step_cnt_in   = step_cnt_ff;
      step_armed_in = step_armed_ff;
      off_new       = 1'b0;

      case (item.command)
         CMD_TICK: begin
            if (!link_ff) begin
               if (fires(fast_cnt_ff, cfg.fast_period_ticks)) begin
                  fast_cnt_in = '0;
                  toggle_in   = !toggle_ff;
                  led_in      = !toggle_ff;
               end else begin
                  fast_cnt_in = fast_cnt_ff + COUNT_WIDTH'(1);
               end
            end else begin
               if (fires(slow_cnt_ff, cfg.slow_period_ticks)) begin
                  slow_cnt_in = '0;
                  // pulse is swallowed while a burst runs
                  if (!burst_ff) begin
                     led_in       = 1'b1;
                     off_armed_in = 1'b1;
                     off_cnt_in   = '0;
                     off_new      = 1'b1;
                  end
               end else begin
                  slow_cnt_in = slow_cnt_ff + COUNT_WIDTH'(1);
               end
            end

            if (off_armed_ff && !off_new) begin
               if (fires(off_cnt_ff, cfg.slow_on_ticks)) begin
                  off_cnt_in   = '0;
                  off_armed_in = 1'b0;
                  if (!burst_ff) begin
                     led_in = 1'b0;
                  end
               end else begin
                  off_cnt_in = off_cnt_ff + COUNT_WIDTH'(1);
               end
            end

            if (step_armed_ff) begin
               if (fires(step_cnt_ff, cfg.burst_step_ticks)) begin
                  step_cnt_in = '0;
                  count_in    = count_ff + LIMIT_WIDTH'(1);
                  led_in      = count_in[0];
                  if (count_in >= cfg.burst_step_limit) begin
                     step_armed_in = 1'b0;
                     burst_in      = 1'b0;
                     count_in      = '0;
                     if (link_ff) begin
                        led_in = 1'b0;
                     end
                  end
               end else begin
                  step_cnt_in = step_cnt_ff + COUNT_WIDTH'(1);
               end
            end
         end

         CMD_LINK: begin
            if (item.connected_level != link_ff) begin
               link_in     = item.connected_level;
               led_in      = 1'b0;
               fast_cnt_in = '0;
               slow_cnt_in = '0;
               if (!item.connected_level) begin
                  off_armed_in = 1'b0;
                  off_cnt_in   = '0;
               end
            end
         end

         CMD_BURST: begin
            if (!burst_ff) begin
               burst_in      = 1'b1;
               count_in      = '0;
               led_in        = 1'b1;
               step_armed_in = 1'b1;
               step_cnt_in   = '0;
            end
         end

         default: begin
            link_in = link_ff;
         end
      endcase
   end

   assign result.led_on        = led_in;
   assign result.burst_running = burst_in;
   assign result.link_up       = link_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff       <= 1'b0;
         toggle_ff     <= 1'b0;
         led_ff        <= 1'b0;
         burst_ff      <= 1'b0;
         count_ff      <= '0;
         fast_cnt_ff   <= '0;
         slow_cnt_ff   <= '0;
         off_cnt_ff    <= '0;
         off_armed_ff  <= 1'b0;
         step_cnt_ff   <= '0;
         step_armed_ff <= 1'b0;
      end else if (item_en) begin
         link_ff       <= link_in;
         toggle_ff     <= toggle_in;
         led_ff        <= led_in;
         burst_ff      <= burst_in;
         count_ff      <= count_in;
         fast_cnt_ff   <= fast_cnt_in;
         slow_cnt_ff   <= slow_cnt_in;
         off_cnt_ff    <= off_cnt_in;
         off_armed_ff  <= off_armed_in;
         step_cnt_ff   <= step_cnt_in;
         step_armed_ff <= step_armed_in;
      end
   end

endmodule

@@ test/status_led_pattern_generator_tb.sv @@
`timescale 1ns / 1ps

module status_led_pattern_generator_tb;
   import slpg_pkg::*;

   localparam int CNT_W = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES = 40;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   slpg_req_type req_item = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   slpg_rsp_type rsp_item;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_AW-1:0] paddr = '0;
   logic [CSR_DW-1:0] pwdata = '0;
   logic [CSR_DW-1:0] prdata;
   logic pready;

   status_led_pattern_generator dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item(rsp_item),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   slpg_req_type command_q[$];
   slpg_rsp_type led_status_q[$];
   int mismatch_count = 0;
   int results_seen = 0;
   int gap_left = 0;
   int stall_left = 0;
   int hold_left = 0;
   int idle_cycles = 0;
   bit pressure_done = 1'b0;
   bit idling_on = 1'b1;

   // Shadow of the block's configuration and state
   slpg_cfg_type led_cfg;
   logic link_mode;
   logic toggle_phase;
   logic led_level;
   logic burst_flag;
   logic [LIMIT_WIDTH-1:0] burst_count;
   logic [CNT_W-1:0] fast_cnt;
   logic [CNT_W-1:0] slow_cnt;
   logic [CNT_W-1:0] off_cnt;
   logic off_armed;
   logic [CNT_W-1:0] step_cnt;
   logic step_armed;

   task automatic clear_led_state();
      led_cfg.fast_period_ticks = FAST_PERIOD_RST;
      led_cfg.slow_period_ticks = SLOW_PERIOD_RST;
      led_cfg.slow_on_ticks = SLOW_ON_RST;
      led_cfg.burst_step_ticks = BURST_STEP_RST;
      led_cfg.burst_step_limit = BURST_LIMIT_RST;
      link_mode = 1'b0;
      toggle_phase = 1'b0;
      led_level = 1'b0;
      burst_flag = 1'b0;
      burst_count = '0;
      fast_cnt = '0;
      slow_cnt = '0;
      off_cnt = '0;
      off_armed = 1'b0;
      step_cnt = '0;
      step_armed = 1'b0;
   endtask

   // Count one tick; fire and clear at the period or at the all-ones value
   function automatic logic timer_step(inout logic [CNT_W-1:0] count,
                                       input logic [PERIOD_WIDTH-1:0] period);
      logic [CNT_W-1:0] next_count;
      next_count = count + CNT_W'(1);
      if (next_count >= period || next_count == '1) begin
         count = '0;
         return 1'b1;
      end
      count = next_count;
      return 1'b0;
   endfunction

   task automatic compute_led_status(input slpg_req_type item, output slpg_rsp_type status);
      logic off_new;
      off_new = 1'b0;
      case (item.command)
         CMD_TICK: begin
            if (!link_mode) begin
               if (timer_step(fast_cnt, led_cfg.fast_period_ticks)) begin
                  toggle_phase = !toggle_phase;
                  led_level = toggle_phase;
               end
            end
            if (link_mode) begin
               if (timer_step(slow_cnt, led_cfg.slow_period_ticks) && !burst_flag) begin
                  led_level = 1'b1;
                  off_armed = 1'b1;
                  off_cnt = '0;
                  off_new = 1'b1;
               end
            end
            // a one-shot armed on this tick does not advance yet
            if (off_armed && !off_new) begin
               if (timer_step(off_cnt, led_cfg.slow_on_ticks)) begin
                  off_armed = 1'b0;
                  if (!burst_flag) led_level = 1'b0;
               end
            end
            if (step_armed) begin
               if (timer_step(step_cnt, led_cfg.burst_step_ticks)) begin
                  step_armed = 1'b0;
                  burst_count = burst_count + LIMIT_WIDTH'(1);
                  led_level = burst_count[0];
                  if (burst_count < led_cfg.burst_step_limit) begin
                     step_armed = 1'b1;
                     step_cnt = '0;
                  end else begin
                     burst_flag = 1'b0;
                     burst_count = '0;
                     if (link_mode) led_level = 1'b0;
                  end
               end
            end
         end
         CMD_LINK: begin
            if (item.connected_level != link_mode) begin
               link_mode = item.connected_level;
               led_level = 1'b0;
               fast_cnt = '0;
               slow_cnt = '0;
               if (!item.connected_level) begin
                  off_armed = 1'b0;
                  off_cnt = '0;
               end
            end
         end
         CMD_BURST: begin
            if (!burst_flag) begin
               burst_flag = 1'b1;
               burst_count = '0;
               led_level = 1'b1;
               step_armed = 1'b1;
               step_cnt = '0;
            end
         end
         default: ;
      endcase
      status.led_on = led_level;
      status.burst_running = burst_flag;
      status.link_up = link_mode;
   endtask

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // Driver: present queued commands, with short random gaps between them
   always @(posedge clock) begin
      slpg_rsp_type status;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            compute_led_status(req_item, status);
            led_status_q.push_back(status);
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (command_q.size() > 0) begin
               req_item <= command_q.pop_front();
               req_valid <= 1'b1;
               if (idling_on && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 3);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each result transfer and drive the receiver stall
   always @(posedge clock) begin
      slpg_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (led_status_q.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with nothing expected",
                                         results_seen));
            end else begin
               want = led_status_q.pop_front();
               if (rsp_item.led_on !== want.led_on)
                  report_mismatch($sformatf("result %0d led_on %b, expected %b",
                                            results_seen, rsp_item.led_on, want.led_on));
               if (rsp_item.burst_running !== want.burst_running)
                  report_mismatch($sformatf("result %0d burst_running %b, expected %b",
                                            results_seen, rsp_item.burst_running,
                                            want.burst_running));
               if (rsp_item.link_up !== want.link_up)
                  report_mismatch($sformatf("result %0d link_up %b, expected %b",
                                            results_seen, rsp_item.link_up, want.link_up));
            end
         end
         // one long hold-off so the block fills and stalls its input
         if (!pressure_done && results_seen >= 100 && command_q.size() > 15) begin
            pressure_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (idling_on && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [CSR_DW-1:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_FAST_PERIOD: led_cfg.fast_period_ticks = value[PERIOD_WIDTH-1:0];
         REG_SLOW_PERIOD: led_cfg.slow_period_ticks = value[PERIOD_WIDTH-1:0];
         REG_SLOW_ON:     led_cfg.slow_on_ticks = value[PERIOD_WIDTH-1:0];
         REG_BURST_STEP:  led_cfg.burst_step_ticks = value[PERIOD_WIDTH-1:0];
         REG_BURST_LIMIT: led_cfg.burst_step_limit = value[LIMIT_WIDTH-1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input int fast, input int slow, input int on_ticks,
                             input int step, input int limit);
      write_reg(REG_FAST_PERIOD, fast);
      write_reg(REG_SLOW_PERIOD, slow);
      write_reg(REG_SLOW_ON, on_ticks);
      write_reg(REG_BURST_STEP, step);
      write_reg(REG_BURST_LIMIT, limit);
   endtask

   task automatic push_cmd(input logic [1:0] cmd, input logic level);
      slpg_req_type item;
      item.command = cmd;
      item.connected_level = level;
      command_q.push_back(item);
   endtask

   // Mostly ticks so the timers run; links, bursts and the unused code mixed in
   task automatic push_random(input int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 58) push_cmd(CMD_TICK, 1'($urandom_range(0, 1)));
         else if (pick < 74) push_cmd(CMD_LINK, 1'($urandom_range(0, 1)));
         else if (pick < 92) push_cmd(CMD_BURST, 1'($urandom_range(0, 1)));
         else push_cmd(CMD_UNUSED, 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic wait_drained();
      while (command_q.size() != 0 || req_valid || led_status_q.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      clear_led_state();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // register defaults
      push_random(15);
      wait_drained();

      // short periods and a limit of two
      set_config(1, 2, 1, 1, 2);
      push_cmd(CMD_TICK, 1'b0);
      push_cmd(CMD_TICK, 1'b1);
      push_cmd(CMD_LINK, 1'b0);
      push_cmd(CMD_LINK, 1'b1);
      push_cmd(CMD_LINK, 1'b1);
      push_cmd(CMD_TICK, 1'b0);
      push_cmd(CMD_TICK, 1'b0);
      push_cmd(CMD_TICK, 1'b0);
      push_cmd(CMD_TICK, 1'b0);
      push_cmd(CMD_BURST, 1'b0);
      push_cmd(CMD_BURST, 1'b1);
      push_cmd(CMD_TICK, 1'b0);
      push_cmd(CMD_TICK, 1'b0);
      push_cmd(CMD_UNUSED, 1'b1);
      push_cmd(CMD_UNUSED, 1'b0);
      push_cmd(CMD_BURST, 1'b0);
      push_cmd(CMD_TICK, 1'b0);
      push_cmd(CMD_LINK, 1'b0);
      push_cmd(CMD_TICK, 1'b0);
      push_cmd(CMD_TICK, 1'b0);
      push_cmd(CMD_TICK, 1'b0);
      push_random(55);
      wait_drained();

      // zero periods and a zero limit
      set_config(0, 0, 0, 0, 0);
      push_random(30);
      wait_drained();

      // limit of one ends the burst at the first step
      set_config(2, 3, 1, 2, 1);
      push_random(30);
      wait_drained();

      // largest periods and a limit of 30
      set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 30);
      push_random(30);
      wait_drained();

      for (int p = 0; p < 5; p++) begin
         set_config($urandom_range(1, 6), $urandom_range(2, 9), $urandom_range(1, 6),
                    $urandom_range(1, 4),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(2, 30) : $urandom_range(2, 6));
         push_random(45);
         wait_drained();
      end

      // final stretch at full rate
      idling_on = 1'b0;
      set_config(3, 4, 2, 1, 3);
      push_random(60);
      wait_drained();
      repeat (4) @(posedge clock);

      if (mismatch_count == 0 && led_status_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
